// ===== rtl/core/lrd_pkg.sv =====
// shared constants, types and helpers of the run-length pattern decoder
`default_nettype none

package lrd_pkg;

  // grid side limit and field widths
  localparam int MAX_SIDE  = 1024;
  localparam int CFG_W     = 11;
  localparam int CHAR_W    = 8;
  localparam int RUN_W     = 21;
  localparam int COUNT_W   = 21;
  localparam int CFG_IDX_W = 1;

  // widths that follow from the side limit
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int COL_W  = $clog2(MAX_SIDE);
  localparam int TOT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int CELL_W = (TOT_W > RUN_W) ? TOT_W : RUN_W;
  localparam int PROD_W = COUNT_W + SIDE_W;
  localparam int WANT_W = PROD_W + 1;
  localparam int DIV_W  = CELL_W + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // pattern text characters
  localparam logic [CHAR_W-1:0] CH_DEAD  = 8'h62;  // 'b'
  localparam logic [CHAR_W-1:0] CH_LIVE  = 8'h6F;  // 'o'
  localparam logic [CHAR_W-1:0] CH_ROW   = 8'h24;  // '$'
  localparam logic [CHAR_W-1:0] CH_END   = 8'h21;  // '!'
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  // controller states
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_MOD1   = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_CLAMP  = 7'b0010000,
    S_MOD2   = 7'b0100000,
    S_DONE   = 7'b1000000
  } lrd_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_char;
    logic decode;
    logic load_col;
    logic mul;
    logic clamp;
    logic finish;
  } lrd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_run;
    logic rem_busy;
    logic out_full;
  } lrd_status_t;

  // register value to effective side: 0 acts as 1, large values clip
  function automatic logic [SIDE_W-1:0] side_of(input logic [CFG_W-1:0] v);
    logic [SIDE_W-1:0] s;
    if (v == '0) begin
      s = SIDE_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = SIDE_W'(v);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lrd_channels.sv =====
// channel interfaces: character input, run output, configuration write
`default_nettype none

interface lrd_char_if;
  import lrd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface lrd_run_if;
  import lrd_pkg::*;
  logic             valid;
  logic             ready;
  logic             cell_value;
  logic [RUN_W-1:0] run_length;
  logic             pattern_end;
  logic             size_ok;
  modport source (output valid, output cell_value, output run_length,
                  output pattern_end, output size_ok, input ready);
  modport sink   (input valid, input cell_value, input run_length,
                  input pattern_end, input size_ok, output ready);
endinterface

interface lrd_cfg_if;
  import lrd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lrd_rem.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none

module lrd_rem (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lrd_pkg::DIV_W-1:0]  dividend,
  input  wire logic [lrd_pkg::SIDE_W-1:0] divisor,
  output logic                           busy,
  output logic [lrd_pkg::SIDE_W-1:0]      rem
);
  import lrd_pkg::*;

  logic [SIDE_W-1:0] acc;
  logic [DIV_W-1:0]  shreg;
  logic [SIDE_W-1:0] dvs;
  logic [DCNT_W-1:0] steps;
  logic [SIDE_W:0]   trial;

  assign busy  = (steps != '0);
  assign rem   = acc;
  // shift next dividend bit into the partial remainder
  assign trial = {acc, shreg[DIV_W-1]};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= DCNT_W'(DIV_W);
    end else if (busy) begin
      steps <= steps - DCNT_W'(1);
    end
  end

  // remainder datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      shreg <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        acc <= SIDE_W'(trial - {1'b0, dvs});
      end else begin
        acc <= trial[SIDE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lrd_datapath.sv =====
// decoder datapath: config, pattern state, run arithmetic, result register
`default_nettype none

module lrd_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lrd_pkg::lrd_cmd_t            cmd,
  output lrd_pkg::lrd_status_t              status,
  input  wire logic [lrd_pkg::CHAR_W-1:0]    char_code,
  input  wire logic                         cfg_we,
  input  wire logic [lrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lrd_pkg::CFG_W-1:0]     cfg_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_cell_value,
  output logic [lrd_pkg::RUN_W-1:0]          out_run_length,
  output logic                              out_pattern_end,
  output logic                              out_size_ok
);
  import lrd_pkg::*;

  // configuration
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;

  // pattern state
  logic [CHAR_W-1:0]  char_q;
  logic [COUNT_W-1:0] pending_count;
  logic               count_poisoned;
  logic [COL_W-1:0]   column;
  logic               row_touched;
  logic [CELL_W-1:0]  cells_emitted;
  logic               grid_overflow;

  // per-item working registers
  logic [TOT_W-1:0]   total;
  logic [COUNT_W-1:0] cnt;
  logic [COL_W-1:0]   col;
  logic [SIDE_W-1:0]  pad;
  logic [PROD_W-1:0]  prod;
  logic [CELL_W-1:0]  left;
  logic [CELL_W-1:0]  granted;

  // combinational helpers
  logic [SIDE_W-1:0]    w;
  logic [SIDE_W-1:0]    h;
  logic [2*SIDE_W-1:0]  wh;
  logic                 is_digit;
  logic                 is_dead;
  logic                 is_live;
  logic                 is_row;
  logic                 is_end;
  logic [COUNT_W+3:0]   times10;
  logic [CELL_W-1:0]    total_c;
  logic [WANT_W-1:0]    want;
  logic                 clip;
  logic [CELL_W-1:0]    n_clamped;
  logic                 rem_start;
  logic [DIV_W-1:0]     rem_dividend;
  logic                 rem_busy;
  logic [SIDE_W-1:0]    rem_value;

  assign w  = side_of(grid_width);
  assign h  = side_of(grid_height);
  assign wh = w * h;

  // character classes
  assign is_digit = char_q inside {[CH_ZERO:CH_NINE]};
  assign is_dead  = (char_q == CH_DEAD);
  assign is_live  = (char_q == CH_LIVE);
  assign is_row   = (char_q == CH_ROW);
  assign is_end   = (char_q == CH_END);

  // decimal count accumulate
  assign times10 = {1'b0, pending_count, 3'b000} + {3'b000, pending_count, 1'b0}
                 + {COUNT_W'(0), char_q[3:0]};

  // run request and clamp to what the grid has left
  assign total_c = CELL_W'(total);
  always_comb begin
    if (is_row) begin
      want = WANT_W'(pad) + WANT_W'(prod);
    end else if (is_end) begin
      want = WANT_W'(pad);
    end else begin
      want = WANT_W'(cnt);
    end
  end
  assign clip      = (want > WANT_W'(left));
  assign n_clamped = clip ? left : want[CELL_W-1:0];

  // remainder unit: column mod width at decode, new column after clamp
  assign rem_start    = (cmd.decode && status.is_run) || cmd.clamp;
  assign rem_dividend = cmd.clamp ? (DIV_W'(col) + DIV_W'(n_clamped)) : DIV_W'(column);

  lrd_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (w),
    .busy     (rem_busy),
    .rem      (rem_value)
  );

  assign status.is_run   = is_dead || is_live || is_row || is_end;
  assign status.rem_busy = rem_busy;
  assign status.out_full = out_valid && !out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_W'(1);
      grid_height <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // character latch
  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_q <= char_code;
    end
  end

  // working registers along the run path
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      total <= wh[TOT_W-1:0];
      cnt   <= (count_poisoned || pending_count == '0) ? COUNT_W'(1) : pending_count;
    end
    if (cmd.load_col) begin
      col <= rem_value[COL_W-1:0];
    end
    if (cmd.mul) begin
      prod <= PROD_W'(cnt - COUNT_W'(1)) * PROD_W'(w);
      if (col != '0) begin
        pad <= w - SIDE_W'(col);
      end else if (is_row && !row_touched) begin
        pad <= w;
      end else begin
        pad <= '0;
      end
      left <= (total_c > cells_emitted) ? (total_c - cells_emitted) : '0;
    end
    if (cmd.clamp) begin
      granted <= n_clamped;
    end
  end

  // pattern state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count  <= '0;
      count_poisoned <= 1'b0;
      column         <= '0;
      row_touched    <= 1'b0;
      cells_emitted  <= '0;
      grid_overflow  <= 1'b0;
    end else begin
      if (cmd.decode && is_digit) begin
        if (times10[COUNT_W+3:COUNT_W] != '0) begin
          pending_count <= '1;
        end else begin
          pending_count <= times10[COUNT_W-1:0];
        end
      end
      if (cmd.decode && !is_digit && !status.is_run) begin
        count_poisoned <= 1'b1;
      end
      if (cmd.clamp) begin
        cells_emitted <= cells_emitted + n_clamped;
        if (clip) begin
          grid_overflow <= 1'b1;
        end
      end
      if (cmd.finish) begin
        pending_count  <= '0;
        count_poisoned <= 1'b0;
        if (is_end) begin
          column        <= '0;
          row_touched   <= 1'b0;
          cells_emitted <= '0;
          grid_overflow <= 1'b0;
        end else begin
          column <= rem_value[COL_W-1:0];
          if (is_row) begin
            row_touched <= 1'b0;
          end else if (granted != '0) begin
            row_touched <= 1'b1;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_cell_value  <= is_live;
      out_run_length  <= granted[RUN_W-1:0];
      out_pattern_end <= is_end;
      out_size_ok     <= is_end && (cells_emitted == total_c) && !grid_overflow;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lrd_ctrl.sv =====
// decoder controller: sequences one character through the datapath
`default_nettype none

module lrd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lrd_pkg::lrd_status_t status,
  output lrd_pkg::lrd_cmd_t         cmd
);
  import lrd_pkg::*;

  lrd_state_t state;
  lrd_state_t state_next;

  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_char = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = status.is_run ? S_MOD1 : S_IDLE;
      end
      S_MOD1: begin
        if (!status.rem_busy) begin
          cmd.load_col = 1'b1;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_MOD2;
      end
      S_MOD2: begin
        if (!status.rem_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // wait until the result register is free
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/life_rle_pattern_decoder_core.sv =====
// top level of the run-length cell pattern decoder
`default_nettype none

// Decodes a run-length pattern body, one character beat at a time, into
// runs of cells over a row-major grid of grid_width by grid_height cells
// (register 0 and register 1; 0 acts as 1, values above 1024 act as 1024).
// A digit or any unknown character gives no result beat. 'b', 'o', '$' and
// '!' each give one run beat; the bit-serial remainder unit runs twice per
// run, once to fold the column into the current width and once to wrap the
// new column, one dividend bit per cycle. A finished run waits in an output
// register, so the next character is accepted while it is unread; the
// decoder only stalls when a second run is done before the first is taken.
// Configuration writes are taken in any cycle and belong between patterns
// or while the decoder is idle.
module life_rle_pattern_decoder_core (
  input  wire logic  clk,
  input  wire logic  rst,
  lrd_char_if.sink   chars,
  lrd_run_if.source  runs,
  lrd_cfg_if.sink    cfg
);
  import lrd_pkg::*;

  lrd_cmd_t    cmd;
  lrd_status_t status;

  // configuration is always writable
  assign cfg.ready = 1'b1;

  lrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (chars.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lrd_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .char_code       (chars.char_code),
    .cfg_we          (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_valid       (runs.valid),
    .out_ready       (runs.ready),
    .out_cell_value  (runs.cell_value),
    .out_run_length  (runs.run_length),
    .out_pattern_end (runs.pattern_end),
    .out_size_ok     (runs.size_ok)
  );

`ifndef SYNTHESIS
  // a new result beat appears only after the controller finished a run
  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(runs.valid) |-> $past(cmd.finish))
    else $error("result beat without a finished run");

  // the remainder unit is never restarted while it is still working
  a_rem_not_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.clamp || (cmd.decode && status.is_run)) |-> !status.rem_busy)
    else $error("remainder unit restarted while busy");

  // an idle decoder has no remainder work in flight
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    chars.ready |-> !status.rem_busy)
    else $error("input ready while remainder unit busy");

  // an accepted character is decoded before another one is taken
  a_one_char: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.ready) |=> !chars.ready)
    else $error("second character accepted before decode");
`endif

endmodule

`default_nettype wire
